>>> hdl/bix_pkg.sv
// ----------------------------------------------------------------------------
// bix_pkg: shared types and codes for the box index range query
// operation codes from the sequencer, status back from the datapath
// ----------------------------------------------------------------------------
package bix_pkg;

  localparam int DATA_W = 32;
  localparam int ID_W   = 12;
  localparam int CNT_W  = 13;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_W-1:0] CFG_MIN_X = 2'd0;
  localparam logic [CFG_W-1:0] CFG_MIN_Y = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MAX_X = 2'd2;
  localparam logic [CFG_W-1:0] CFG_MAX_Y = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] lx;
    logic signed [DATA_W-1:0] ly;
    logic signed [DATA_W-1:0] hx;
    logic signed [DATA_W-1:0] hy;
  } box_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RESTART,
    OP_LEAF,
    OP_RD_CUR,
    OP_RD_TOP,
    OP_C_INIT,
    OP_C_CAP,
    OP_RD_K,
    OP_C_WR,
    OP_M_WR,
    OP_F_END,
    OP_F_EVAL,
    OP_F_UP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic              clr_last;
    logic [KIND_W-1:0] kind;
    logic              ins_bad;
    logic              carry_need;
    logic              k_last;
    logic              ins_stop;
    logic              pos_end;
    logic              ev_done;
    logic              ev_desc;
    logic              up_need;
    logic              out_free;
  } st_t;

  // grow a box so that it also covers src
  function automatic box_t box_merge(box_t dst, box_t src);
    box_t m;
    m.lx = (src.lx < dst.lx) ? src.lx : dst.lx;
    m.ly = (src.ly < dst.ly) ? src.ly : dst.ly;
    m.hx = (src.hx > dst.hx) ? src.hx : dst.hx;
    m.hy = (src.hy > dst.hy) ? src.hy : dst.hy;
    return m;
  endfunction

endpackage

>>> hdl/bix_ctrl.sv
// ----------------------------------------------------------------------------
// bix_ctrl: sequencer for the box index range query
// walks the clear sweep, inserts, root rises, restarts, range walks and the result beat
// ----------------------------------------------------------------------------
module bix_ctrl import bix_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  st_t  st,
  output op_t  op
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_INS_CHK, S_C1, S_C2, S_C3, S_M_WR,
    S_F_CHK, S_F_EV, S_F_UP, S_TOT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_CLR: begin
        op = OP_CLEAR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.kind)
          KIND_INSERT: begin
            if (st.ins_bad) begin
              state_nxt = S_TOT;
            end else begin
              op        = OP_LEAF;
              state_nxt = S_INS_CHK;
            end
          end
          KIND_FETCH:   state_nxt = S_F_CHK;
          KIND_RESTART: begin
            op        = OP_RESTART;
            state_nxt = S_TOT;
          end
          default:      state_nxt = S_TOT;
        endcase
      end
      S_INS_CHK: begin
        if (st.carry_need) begin
          op        = OP_C_INIT;
          state_nxt = S_C1;
        end else begin
          op        = OP_RD_CUR;
          state_nxt = S_M_WR;
        end
      end
      S_C1: begin
        op        = OP_C_CAP;
        state_nxt = S_C2;
      end
      S_C2: begin
        op        = OP_C_WR;
        state_nxt = st.k_last ? S_INS_CHK : S_C3;
      end
      S_C3: begin
        op        = OP_RD_K;
        state_nxt = S_C2;
      end
      S_M_WR: begin
        op        = OP_M_WR;
        state_nxt = st.ins_stop ? S_TOT : S_INS_CHK;
      end
      S_F_CHK: begin
        if (st.pos_end) begin
          op        = OP_F_END;
          state_nxt = S_TOT;
        end else begin
          op        = OP_RD_CUR;
          state_nxt = S_F_EV;
        end
      end
      S_F_EV: begin
        op = OP_F_EVAL;
        if (st.ev_done)      state_nxt = S_TOT;
        else if (st.ev_desc) state_nxt = S_F_CHK;
        else                 state_nxt = S_F_UP;
      end
      S_F_UP: begin
        if (st.up_need) op = OP_F_UP;
        else            state_nxt = S_F_CHK;
      end
      S_TOT: begin
        op        = OP_RD_TOP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule

>>> hdl/bix_dp.sv
// ----------------------------------------------------------------------------
// bix_dp: node store and walk registers of the box index range query
// one node memory, one read or write per cycle, query and result registers
// ----------------------------------------------------------------------------
module bix_dp import bix_pkg::*; #(
  parameter int MAX_ITEMS    = 4096,
  parameter int FANOUT_SHIFT = 4,
  parameter int LEVEL_COUNT  = 4,
  parameter int COORD_BITS   = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  op_t                      op,
  output st_t                      st,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [ID_W-1:0]          in_item_id,
  input  logic signed [DATA_W-1:0] in_box_min_x,
  input  logic signed [DATA_W-1:0] in_box_min_y,
  input  logic signed [DATA_W-1:0] in_box_max_x,
  input  logic signed [DATA_W-1:0] in_box_max_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [CNT_W-1:0]         out_range_start,
  output logic [CNT_W-1:0]         out_range_end,
  output logic signed [DATA_W-1:0] out_total_min_x,
  output logic signed [DATA_W-1:0] out_total_min_y,
  output logic signed [DATA_W-1:0] out_total_max_x,
  output logic signed [DATA_W-1:0] out_total_max_y
);

  localparam int ITEMS_EFF = (MAX_ITEMS < (1 << ID_W)) ? MAX_ITEMS : (1 << ID_W);
  localparam int IDX_W     = $clog2(ITEMS_EFF);
  localparam int LV_W      = (LEVEL_COUNT > 2) ? $clog2(LEVEL_COUNT) : 1;
  localparam int AW        = LV_W + IDX_W;
  localparam int MEM_DEPTH = LEVEL_COUNT * (1 << IDX_W);
  localparam int MEM_W     = 4 * COORD_BITS;
  localparam int POS_W     = CNT_W + FANOUT_SHIFT * (LEVEL_COUNT - 1);
  localparam longint C_HI_L = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [DATA_W-1:0] C_HI = DATA_W'(C_HI_L);
  localparam logic signed [DATA_W-1:0] C_LO = -C_HI - 32'sd1;

  function automatic logic signed [DATA_W-1:0] sat(logic signed [DATA_W-1:0] v);
    if (v > C_HI) return C_HI;
    if (v < C_LO) return C_LO;
    return v;
  endfunction

  function automatic logic [MEM_W-1:0] pack(box_t b);
    return {b.hy[COORD_BITS-1:0], b.hx[COORD_BITS-1:0],
            b.ly[COORD_BITS-1:0], b.lx[COORD_BITS-1:0]};
  endfunction

  function automatic box_t unpack(logic [MEM_W-1:0] w);
    box_t b;
    b.lx = DATA_W'(signed'(w[COORD_BITS-1:0]));
    b.ly = DATA_W'(signed'(w[2*COORD_BITS-1:COORD_BITS]));
    b.hx = DATA_W'(signed'(w[3*COORD_BITS-1:2*COORD_BITS]));
    b.hy = DATA_W'(signed'(w[4*COORD_BITS-1:3*COORD_BITS]));
    return b;
  endfunction

  // node memory
  logic [MEM_W-1:0] mem_q [MEM_DEPTH];
  logic [MEM_W-1:0] rd_raw_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [MEM_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_raw_r <= mem_q[mem_ra];
  end

  // state
  box_t              query_r;
  box_t              item_box_r;
  box_t              carry_r;
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   item_id_r;
  logic [CNT_W-1:0]  leaf_r;
  logic [LV_W-1:0]   top_r;
  logic [CNT_W-1:0]  walk_index_r;
  logic [LV_W-1:0]   walk_level_r;
  logic [CNT_W-1:0]  ix_r;
  logic [LV_W-1:0]   lv_r;
  logic [LV_W-1:0]   k_r;
  logic              have_r;
  logic [CNT_W-1:0]  s_r;
  logic              res_found_r;
  logic [CNT_W-1:0]  rs_r, re_r;
  logic [AW-1:0]     clr_r;
  logic              out_valid_r;
  box_t              total_r;
  logic              out_found_r;
  logic [CNT_W-1:0]  out_rs_r, out_re_r;

  box_t             rd_box, blank_box, merged;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] pos_cnt;
  logic             miss, cov;

  always_comb begin
    blank_box.lx = C_HI;
    blank_box.ly = C_HI;
    blank_box.hx = C_LO;
    blank_box.hy = C_LO;
    rd_box  = unpack(rd_raw_r);
    pos     = POS_W'(ix_r) << (int'(lv_r) * FANOUT_SHIFT);
    pos_cnt = pos[CNT_W-1:0];
    miss = (rd_box.lx > rd_box.hx) || (rd_box.ly > rd_box.hy) ||
           (rd_box.lx > query_r.hx) || (rd_box.ly > query_r.hy) ||
           (rd_box.hx < query_r.lx) || (rd_box.hy < query_r.ly);
    cov  = (query_r.lx <= rd_box.lx) && (query_r.ly <= rd_box.ly) &&
           (rd_box.hx <= query_r.hx) && (rd_box.hy <= query_r.hy);
    merged = (op == OP_C_WR) ? box_merge(rd_box, carry_r) : box_merge(rd_box, item_box_r);
  end

  // memory port select
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = pack(merged);
    case (op)
      OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = pack(blank_box);
      end
      OP_RD_CUR: begin
        mem_re = 1'b1;
        mem_ra = {lv_r, ix_r[IDX_W-1:0]};
      end
      OP_RD_TOP, OP_C_INIT: begin
        mem_re = 1'b1;
        mem_ra = {top_r, {IDX_W{1'b0}}};
      end
      OP_C_CAP, OP_RD_K: begin
        mem_re = 1'b1;
        mem_ra = {k_r, {IDX_W{1'b0}}};
      end
      OP_C_WR: begin
        mem_we = 1'b1;
        mem_wa = {k_r, {IDX_W{1'b0}}};
      end
      OP_M_WR: begin
        mem_we = 1'b1;
        mem_wa = {lv_r, ix_r[IDX_W-1:0]};
      end
      default: ;
    endcase
  end

  // status to the sequencer
  always_comb begin
    st.clr_last   = (clr_r == AW'(MEM_DEPTH - 1));
    st.kind       = kind_r;
    st.ins_bad    = (32'(item_id_r) >= 32'(MAX_ITEMS));
    st.carry_need = (ix_r == '0) && (lv_r > top_r);
    st.k_last     = (k_r == lv_r);
    st.ins_stop   = ((ix_r == '0) && (lv_r >= top_r)) || (lv_r == LV_W'(LEVEL_COUNT - 1));
    st.pos_end    = (pos >= POS_W'(leaf_r));
    st.ev_done    = miss && have_r;
    st.ev_desc    = !miss && (lv_r != '0) && !cov;
    st.up_need    = (ix_r[FANOUT_SHIFT-1:0] == '0) && (lv_r < top_r);
    st.out_free   = !out_valid_r || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r      <= '0;
      leaf_r       <= '0;
      top_r        <= '0;
      walk_index_r <= '0;
      walk_level_r <= '0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_X: query_r.lx <= cfg_data;
          CFG_MIN_Y: query_r.ly <= cfg_data;
          CFG_MAX_X: query_r.hx <= cfg_data;
          CFG_MAX_Y: query_r.hy <= cfg_data;
          default: ;
        endcase
      end
      if (op == OP_CLEAR) clr_r <= clr_r + AW'(1);
      if (op == OP_LEAF && (CNT_W'(item_id_r) + CNT_W'(1)) > leaf_r)
        leaf_r <= CNT_W'(item_id_r) + CNT_W'(1);
      if (op == OP_C_WR && k_r == lv_r) top_r <= lv_r;
      if (op == OP_RESTART) begin
        walk_index_r <= '0;
        walk_level_r <= top_r;
      end
      if ((op == OP_F_END && have_r) || (op == OP_F_EVAL && miss && have_r)) begin
        walk_index_r <= ix_r;
        walk_level_r <= lv_r;
      end
      if (op == OP_EMIT)     out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        kind_r        <= in_kind;
        item_id_r     <= in_item_id;
        item_box_r.lx <= sat(in_box_min_x);
        item_box_r.ly <= sat(in_box_min_y);
        item_box_r.hx <= sat(in_box_max_x);
        item_box_r.hy <= sat(in_box_max_y);
        have_r        <= 1'b0;
        s_r           <= '0;
        res_found_r   <= 1'b0;
        rs_r          <= '0;
        re_r          <= '0;
        if (in_kind == KIND_FETCH) begin
          ix_r <= walk_index_r;
          lv_r <= (walk_level_r > top_r) ? top_r : walk_level_r;
        end else begin
          ix_r <= CNT_W'(in_item_id);
          lv_r <= '0;
        end
      end
      OP_C_INIT: k_r <= top_r + LV_W'(1);
      OP_C_CAP:  carry_r <= rd_box;
      OP_C_WR: begin
        carry_r <= merged;
        if (k_r != lv_r) k_r <= k_r + LV_W'(1);
      end
      OP_M_WR: begin
        if (!st.ins_stop) begin
          lv_r <= lv_r + LV_W'(1);
          ix_r <= ix_r >> FANOUT_SHIFT;
        end
      end
      OP_F_END: begin
        if (have_r) begin
          res_found_r <= 1'b1;
          rs_r        <= s_r;
          re_r        <= leaf_r;
        end
      end
      OP_F_EVAL: begin
        if (miss && have_r) begin
          res_found_r <= 1'b1;
          rs_r        <= s_r;
          re_r        <= pos_cnt;
        end else if (!miss && lv_r != '0 && !cov) begin
          lv_r <= lv_r - LV_W'(1);
          ix_r <= CNT_W'(ix_r << FANOUT_SHIFT);
        end else begin
          if (!miss && !have_r) begin
            have_r <= 1'b1;
            s_r    <= pos_cnt;
          end
          ix_r <= ix_r + CNT_W'(1);
        end
      end
      OP_F_UP: begin
        lv_r <= lv_r + LV_W'(1);
        ix_r <= ix_r >> FANOUT_SHIFT;
      end
      OP_EMIT: begin
        total_r     <= rd_box;
        out_found_r <= res_found_r;
        out_rs_r    <= rs_r;
        out_re_r    <= re_r;
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_range_start = out_rs_r;
  assign out_range_end   = out_re_r;
  assign out_total_min_x = total_r.lx;
  assign out_total_min_y = total_r.ly;
  assign out_total_max_x = total_r.hx;
  assign out_total_max_y = total_r.hy;

endmodule

>>> hdl/box_index_range_query.sv
// ----------------------------------------------------------------------------
// box_index_range_query: bounding box hierarchy with a resumable range walk
// top level joining the sequencer and the node datapath
// ----------------------------------------------------------------------------
// One item is handled at a time. After reset the node store is swept to empty
// boxes, one node a cycle, all LEVEL_COUNT * min(MAX_ITEMS, 4096) nodes with
// the per-level count rounded up to a power of two (16384 at the defaults),
// with in_ready low. An insert reads and rewrites the node on each level
// touched, and a root rise merges the old root box into each new level; a
// fetch reads each node, then descends, takes or skips it, climbs levels where
// a group is finished, and stops when the walk runs off the last id or a node
// misses after the range began; restart and unused kinds go to the result.
// The single-port node memory allows one access per cycle. Every item yields
// one result beat, held in an output register so the next item can be taken.
module box_index_range_query import bix_pkg::*; #(
  parameter int MAX_ITEMS    = 4096,
  parameter int FANOUT_SHIFT = 4,
  parameter int LEVEL_COUNT  = 4,
  parameter int COORD_BITS   = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration writes, search box
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // item channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [ID_W-1:0]          in_item_id,
  input  logic signed [DATA_W-1:0] in_box_min_x,
  input  logic signed [DATA_W-1:0] in_box_min_y,
  input  logic signed [DATA_W-1:0] in_box_max_x,
  input  logic signed [DATA_W-1:0] in_box_max_y,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [CNT_W-1:0]         out_range_start,
  output logic [CNT_W-1:0]         out_range_end,
  output logic signed [DATA_W-1:0] out_total_min_x,
  output logic signed [DATA_W-1:0] out_total_min_y,
  output logic signed [DATA_W-1:0] out_total_max_x,
  output logic signed [DATA_W-1:0] out_total_max_y
);

  op_t op;   // one datapath operation per cycle
  st_t st;   // datapath status back to the sequencer

  // sequencer: clear sweep, insert levels, root rise, walk steps
  bix_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  // node memory, walk state, query box and result registers
  bix_dp #(
    .MAX_ITEMS    (MAX_ITEMS),
    .FANOUT_SHIFT (FANOUT_SHIFT),
    .LEVEL_COUNT  (LEVEL_COUNT),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_item_id      (in_item_id),
    .in_box_min_x    (in_box_min_x),
    .in_box_min_y    (in_box_min_y),
    .in_box_max_x    (in_box_max_x),
    .in_box_max_y    (in_box_max_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_range_start (out_range_start),
    .out_range_end   (out_range_end),
    .out_total_min_x (out_total_min_x),
    .out_total_min_y (out_total_min_y),
    .out_total_max_x (out_total_max_x),
    .out_total_max_y (out_total_max_y)
  );

  // the clear sweep holds off items right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready) else $error("item taken during clear sweep");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");

  // a found range is never empty
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_range_start < out_range_end)
    else $error("empty or reversed range");

  // not found beats carry zero range fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_range_start == '0 && out_range_end == '0)
    else $error("range fields set on a miss");

endmodule
